// ----- rtl/world_to_screen_projection_unit_defines.svh -----
// Assertion macros shared by the checker.
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH

// Implication in the same cycle, ignored during reset.
`define WTSP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, ignored during reset.
`define WTSP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication in the next cycle, checked through reset as well.
`define WTSP_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wtsp_pkg.sv -----
`timescale 1ns / 1ps
package wtsp_pkg;

   localparam int NUM_PAIRS    = 8;
   localparam int ADDR_W       = 6;
   localparam int DATA_W       = 64;
   localparam int PT_W         = 32;
   localparam int CLIP_W       = 50;
   localparam int MAG_W        = 49;
   localparam int HALF_W       = 13;
   localparam int NUM_W        = MAG_W + HALF_W;
   localparam int QUO_W        = 32;
   localparam int DEF_WIDTH    = 1920;
   localparam int DEF_HEIGHT   = 1080;
   localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(655);

   typedef struct packed {
      logic signed [PT_W-1:0] point_x;
      logic signed [PT_W-1:0] point_y;
      logic signed [PT_W-1:0] point_z;
   } pt_type;

   typedef struct packed {
      logic                   visible;
      logic signed [PT_W-1:0] pixel_x;
      logic signed [PT_W-1:0] pixel_y;
   } res_type;

   typedef logic [DATA_W-1:0] coef_arr_type [NUM_PAIRS];

   // one lane of the long division
   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] lo;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic             visible;
      logic [MAG_W-1:0] w;
      lane_type         lx;
      lane_type         ly;
   } div_type;

   function automatic logic signed [PT_W-1:0] coef_of(coef_arr_type c, int e);
      logic [DATA_W-1:0] pair;
      pair = c[e / 2];
      return (e % 2 == 1) ? pair[DATA_W-1:PT_W] : pair[PT_W-1:0];
   endfunction

endpackage

// ----- rtl/wtsp_front.sv -----
`timescale 1ns / 1ps
module wtsp_front #(
   parameter int SCREEN_WIDTH  = wtsp_pkg::DEF_WIDTH,
   parameter int SCREEN_HEIGHT = wtsp_pkg::DEF_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wtsp_pkg::coef_arr_type    coef,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  wtsp_pkg::pt_type          in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output wtsp_pkg::div_type         out_data
);
   import wtsp_pkg::*;

   localparam logic [HALF_W-1:0] HALF_X = HALF_W'(SCREEN_WIDTH / 2);
   localparam logic [HALF_W-1:0] HALF_Y = HALF_W'(SCREEN_HEIGHT / 2);
   localparam int PROD_W = 2 * PT_W;
   localparam int SUM_W  = PROD_W + 2;

   // stage A: products, stage B: clip sums, stage C: scale, stage D: division setup
   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PT_W-1:0]   trans_ff [3];
   logic signed [CLIP_W-1:0] clip_ff [3];
   logic signed [CLIP_W-1:0] clip_in [3];

   logic             vis_c_ff, neg_x_c_ff, neg_y_c_ff;
   logic [MAG_W-1:0] w_c_ff;
   logic [NUM_W-1:0] n_x_c_ff, n_y_c_ff;
   logic [MAG_W-1:0] mag_x, mag_y;

   div_type d_ff, d_in;

   assign rdy_d    = !vd_ff || out_ready;
   assign rdy_c    = !vc_ff || rdy_d;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         logic signed [SUM_W-1:0] s;
         s = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1]) + SUM_W'(prod_ff[r][2]);
         clip_in[r] = s[SUM_W-1:16] + CLIP_W'(trans_ff[r]);
      end
   end

   assign mag_x = clip_ff[0][CLIP_W-1] ? MAG_W'(-clip_ff[0]) : clip_ff[0][MAG_W-1:0];
   assign mag_y = clip_ff[1][CLIP_W-1] ? MAG_W'(-clip_ff[1]) : clip_ff[1][MAG_W-1:0];

   function automatic lane_type lane_setup(logic neg, logic [NUM_W-1:0] n,
                                           logic [MAG_W-1:0] w);
      lane_type l;
      l.neg = neg;
      l.sat = ({3'b0, n} >= {w, 16'h0});
      l.rem = MAG_W'(n[NUM_W-1:16]);
      l.lo  = {n[15:0], 16'h0};
      l.quo = '0;
      return l;
   endfunction

   always_comb begin
      d_in.visible = vis_c_ff;
      d_in.w       = w_c_ff;
      d_in.lx      = lane_setup(neg_x_c_ff, n_x_c_ff, w_c_ff);
      d_in.ly      = lane_setup(neg_y_c_ff, n_y_c_ff, w_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   // rows 0, 1 and 3 of the matrix give clip x, y and w
   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= in_data.point_x * coef_of(coef, (r == 2 ? 3 : r) * 4);
            prod_ff[r][1] <= in_data.point_y * coef_of(coef, (r == 2 ? 3 : r) * 4 + 1);
            prod_ff[r][2] <= in_data.point_z * coef_of(coef, (r == 2 ? 3 : r) * 4 + 2);
            trans_ff[r]   <= coef_of(coef, (r == 2 ? 3 : r) * 4 + 3);
         end
      end
      if (rdy_b && va_ff) clip_ff <= clip_in;
      if (rdy_c && vb_ff) begin
         vis_c_ff   <= (clip_ff[2] >= W_MIN);
         w_c_ff     <= (clip_ff[2] >= W_MIN) ? clip_ff[2][MAG_W-1:0] : MAG_W'(1);
         neg_x_c_ff <= clip_ff[0][CLIP_W-1];
         neg_y_c_ff <= clip_ff[1][CLIP_W-1];
         n_x_c_ff   <= NUM_W'(mag_x) * NUM_W'(HALF_X);
         n_y_c_ff   <= NUM_W'(mag_y) * NUM_W'(HALF_Y);
      end
      if (rdy_d && vc_ff) d_ff <= d_in;
   end

   assign out_valid = vd_ff;
   assign out_data  = d_ff;

endmodule

// ----- rtl/wtsp_div_cell.sv -----
`timescale 1ns / 1ps
module wtsp_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  wtsp_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output wtsp_pkg::div_type out_data
);
   import wtsp_pkg::*;

   logic    v_ff;
   div_type d_ff, d_in;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   function automatic lane_type step(lane_type l, logic [MAG_W-1:0] w);
      lane_type         o;
      logic [MAG_W:0]   r2;
      logic             ge;
      r2    = {l.rem, l.lo[QUO_W-1]};
      ge    = (r2 >= {1'b0, w});
      o     = l;
      o.rem = ge ? MAG_W'(r2 - {1'b0, w}) : r2[MAG_W-1:0];
      o.lo  = {l.lo[QUO_W-2:0], 1'b0};
      o.quo = {l.quo[QUO_W-2:0], ge};
      return o;
   endfunction

   always_comb begin
      d_in    = in_data;
      d_in.lx = step(in_data.lx, in_data.w);
      d_in.ly = step(in_data.ly, in_data.w);
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

// ----- rtl/world_to_screen_projection_unit.sv -----
`timescale 1ns / 1ps
// World-to-screen projection of one point per transaction.
// req_*: valid/ready input channel carrying a world point (x, y, z, Q16.16).
// rsp_*: valid/ready result channel carrying visible, pixel_x, pixel_y (Q16.16).
// csr_*: APB-style port with eight 64-bit coefficient pair registers at
//        byte addresses 0, 8, ..., 56; pready is tied high, reads return data.
// From request to response, four stages form the clip coordinates and set up the
// division, a chain of 32 divider cells produces one quotient bit each, and one
// output stage adds the screen offset and saturates. One transaction is accepted
// per cycle while no stall holds the pipeline; the divider chain holds up to 32
// points in flight.
// Each stage has its own valid bit, so a stalled rsp_ready only holds the
// stages that are full; empty stages keep accepting until the chain is full.
// Reset clears all valid bits and zeroes the coefficient registers.
module world_to_screen_projection_unit #(
   parameter int SCREEN_WIDTH  = wtsp_pkg::DEF_WIDTH,
   parameter int SCREEN_HEIGHT = wtsp_pkg::DEF_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wtsp_pkg::pt_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wtsp_pkg::res_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wtsp_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [wtsp_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [wtsp_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import wtsp_pkg::*;

   localparam int NCELL  = QUO_W;
   localparam int ACC_W  = QUO_W + 3;
   localparam logic signed [ACC_W-1:0] OFS_X = ACC_W'((SCREEN_WIDTH / 2) * 65536);
   localparam logic signed [ACC_W-1:0] OFS_Y = ACC_W'((SCREEN_HEIGHT / 2) * 65536);
   localparam logic signed [ACC_W-1:0] PMAX  = ACC_W'(64'sh7FFFFFFF);
   localparam logic signed [ACC_W-1:0] PMIN  = -ACC_W'(64'sh80000000);

   coef_arr_type coef_ff;
   logic [$clog2(NUM_PAIRS)-1:0] idx;

   logic    cv [NCELL+1];
   logic    cr [NCELL+1];
   div_type cd [NCELL+1];

   logic    o_v_ff, o_rdy;
   res_type o_ff, o_in;

   assign idx        = csr_paddr[ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign csr_prdata = coef_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAIRS; i++) coef_ff[i] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         coef_ff[idx] <= csr_pwdata;
      end
   end

   wtsp_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_data  (cd[0])
   );

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      wtsp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[g]),
         .in_ready  (cr[g]),
         .in_data   (cd[g]),
         .out_valid (cv[g+1]),
         .out_ready (cr[g+1]),
         .out_data  (cd[g+1])
      );
   end

   function automatic logic signed [PT_W-1:0] finish(lane_type l,
                                                      logic signed [ACC_W-1:0] ofs);
      logic signed [ACC_W-1:0] v;
      v = l.neg ? -ACC_W'(l.quo) : ACC_W'(l.quo);
      v = v + ofs;
      if (l.sat) v = l.neg ? PMIN : PMAX;
      else if (v > PMAX) v = PMAX;
      else if (v < PMIN) v = PMIN;
      return v[PT_W-1:0];
   endfunction

   always_comb begin
      o_in.visible = cd[NCELL].visible;
      o_in.pixel_x = cd[NCELL].visible ? finish(cd[NCELL].lx, OFS_X) : '0;
      o_in.pixel_y = cd[NCELL].visible ? finish(cd[NCELL].ly, OFS_Y) : '0;
   end

   assign o_rdy     = !o_v_ff || rsp_ready;
   assign cr[NCELL] = o_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_rdy) begin
         o_v_ff <= cv[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (o_rdy && cv[NCELL]) o_ff <= o_in;
   end

   assign rsp_valid = o_v_ff;
   assign rsp_data  = o_ff;

endmodule

// ----- rtl/wtsp_checker.sv -----
`timescale 1ns / 1ps
`include "world_to_screen_projection_unit_defines.svh"
module wtsp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input wtsp_pkg::pt_type              req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input wtsp_pkg::res_type             rsp_data,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [wtsp_pkg::ADDR_W-1:0]   csr_paddr,
   input logic [wtsp_pkg::DATA_W-1:0]   csr_pwdata,
   input logic [wtsp_pkg::DATA_W-1:0]   csr_prdata,
   input logic                          csr_pready
);
   import wtsp_pkg::*;

   `WTSP_ASSERT_ALWAYS_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid,
      "response valid after reset")

   `WTSP_ASSERT_NOW(a_hidden_is_zero, clock, reset, rsp_valid && !rsp_data.visible,
      rsp_data.pixel_x == 0 && rsp_data.pixel_y == 0, "hidden point with nonzero pixels")

   `WTSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled response changed")

   `WTSP_ASSERT_NEXT(a_csr_readback, clock, reset,
      csr_psel && csr_penable && csr_pwrite,
      csr_paddr != $past(csr_paddr) || csr_prdata == $past(csr_pwdata),
      "register readback differs from last write")

endmodule

bind world_to_screen_projection_unit wtsp_checker u_wtsp_checker (.*);

// ----- tb/sv/world_to_screen_projection_unit_tb.sv -----
`timescale 1ns / 1ps
module world_to_screen_projection_unit_tb;
   import wtsp_pkg::*;

   localparam int  HALF_X     = DEF_WIDTH / 2;
   localparam int  HALF_Y     = DEF_HEIGHT / 2;
   localparam int  W_FLOOR    = 655;
   localparam int  IDLE_LIMIT = 20000;
   localparam int  DRAIN_WAIT = 45;
   localparam int  NUM_RANDOM = 1450;
   localparam int  NUM_PHASES = 10;

   localparam logic [31:0] ONE_Q   = 32'h0001_0000;
   localparam logic [31:0] MAX_Q   = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_Q   = 32'h8000_0000;

   typedef enum int {
      MAT_RESET, MAT_W_IS_Z, MAT_ALL_ONES, MAT_ALL_MIN, MAT_ALL_MAX
   } matrix_kind_type;

   typedef struct {
      matrix_kind_type kind;
      pt_type          pt;
      bit              known;
      res_type         res;
   } dir_row_type;

   logic clock = 0;
   logic reset;
   logic req_valid;
   logic req_ready;
   pt_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   res_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic [DATA_W-1:0] coef_mirror [NUM_PAIRS];
   res_type screen_q [$];
   logic    typed_known;
   res_type typed_res;
   int      errors = 0;
   int      idle_cycles = 0;
   bit      long_stall_req = 0;

   always #1 clock = ~clock;

   world_to_screen_projection_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic longint coef_entry(int e);
      logic [DATA_W-1:0] pair;
      pair = coef_mirror[e / 2];
      return (e % 2 == 1) ? longint'($signed(pair[63:32])) : longint'($signed(pair[31:0]));
   endfunction

   // exact Q32.32 products, floored back to Q16.16, plus translation
   function automatic longint clip_coord(int row, longint px, longint py, longint pz);
      longint p0, p1, p2, h;
      p0 = px * coef_entry(row * 4);
      p1 = py * coef_entry(row * 4 + 1);
      p2 = pz * coef_entry(row * 4 + 2);
      h = (p0 >>> 16) + (p1 >>> 16) + (p2 >>> 16);
      h += ((p0 & 64'hFFFF) + (p1 & 64'hFFFF) + (p2 & 64'hFFFF)) / 65536;
      return h + coef_entry(row * 4 + 3);
   endfunction

   function automatic logic [31:0] to_pixel(longint c, longint w, longint half);
      bit neg;
      longint unsigned mag, num, quo, rem, uw;
      longint val;
      neg = c < 0;
      mag = neg ? -c : c;
      uw  = w;
      num = half * mag;
      quo = num / uw;
      rem = num % uw;
      if (quo >= 65536) return neg ? MIN_Q : MAX_Q;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= uw) begin
            rem -= uw;
            quo |= 1;
         end
      end
      val = neg ? -longint'(quo) : longint'(quo);
      val += half * 65536;
      if (val > 64'sh7FFF_FFFF) val = 64'sh7FFF_FFFF;
      if (val < -64'sh8000_0000) val = -64'sh8000_0000;
      return val[31:0];
   endfunction

   function automatic res_type project_point(pt_type p);
      res_type r;
      longint cx, cy, cw;
      cx = clip_coord(0, p.point_x, p.point_y, p.point_z);
      cy = clip_coord(1, p.point_x, p.point_y, p.point_z);
      cw = clip_coord(3, p.point_x, p.point_y, p.point_z);
      r = '0;
      if (cw >= W_FLOOR) begin
         r.visible = 1'b1;
         r.pixel_x = to_pixel(cx, cw, HALF_X);
         r.pixel_y = to_pixel(cy, cw, HALF_Y);
      end
      return r;
   endfunction

   function automatic logic [63:0] matrix_pair(matrix_kind_type kind, int k);
      case (kind)
         MAT_W_IS_Z: begin
            // x -> clip x, y -> clip y, z -> clip w
            if (k == 0) return {32'h0, ONE_Q};
            if (k == 2) return {ONE_Q, 32'h0};
            if (k == 7) return {32'h0, ONE_Q};
            return '0;
         end
         MAT_ALL_ONES: return '1;
         MAT_ALL_MIN:  return {MIN_Q, MIN_Q};
         MAT_ALL_MAX:  return {MAX_Q, MAX_Q};
         default:      return '0;
      endcase
   endfunction

   function automatic logic [31:0] rand_coef(bit sane);
      if (!sane) return $urandom;
      return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
   endfunction

   function automatic pt_type rand_point();
      pt_type p;
      if ($urandom_range(0, 9) < 7) begin
         p.point_x = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
         p.point_y = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
         p.point_z = 32'($urandom_range(0, 1 << 27)) - 32'(1 << 26);
      end else begin
         p.point_x = $urandom;
         p.point_y = $urandom;
         p.point_z = $urandom;
      end
      return p;
   endfunction

   task automatic csr_write(int idx, logic [63:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(idx * 8);
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      coef_mirror[idx] = val;
      @(posedge clock);
   endtask

   task automatic drain();
      while (screen_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic send_point(pt_type p, bit known, res_type r);
      req_valid   <= 1'b1;
      req_data    <= p;
      typed_known <= known;
      typed_res   <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // prediction at input acceptance, checking at output acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            screen_q.push_back(typed_known ? typed_res : project_point(req_data));
         if (rsp_valid && rsp_ready) begin
            if (screen_q.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               res_type e;
               e = screen_q.pop_front();
               if (e.visible !== rsp_data.visible) begin
                  $display("%0t: visible expected %0b actual %0b",
                           $time, e.visible, rsp_data.visible);
                  errors++;
               end
               if (e.pixel_x !== rsp_data.pixel_x) begin
                  $display("%0t: pixel_x expected %h actual %h",
                           $time, e.pixel_x, rsp_data.pixel_x);
                  errors++;
               end
               if (e.pixel_y !== rsp_data.pixel_y) begin
                  $display("%0t: pixel_y expected %h actual %h",
                           $time, e.pixel_y, rsp_data.pixel_y);
                  errors++;
               end
            end
         end
      end
   end

   // receiver: changing stall patterns, plus one long hold-off on request
   initial begin
      int mode;
      int left;
      int hold;
      rsp_ready <= 1'b0;
      mode = 0;
      left = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (long_stall_req && hold == 0) begin
            hold = 400;
            long_stall_req = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 96);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (left % 5 != 0);
            endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      dir_row_type rows [$];
      dir_row_type row;
      matrix_kind_type cur;
      res_type none;
      res_type r;
      int burst;
      int per_phase;
      bit sane;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      typed_known <= 1'b0;
      typed_res   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      for (int k = 0; k < NUM_PAIRS; k++) coef_mirror[k] = '0;
      none = '0;

      // zero matrix: w is zero, nothing is visible
      rows.push_back('{MAT_RESET, '{32'h0, 32'h0, 32'h0}, 1, none});
      rows.push_back('{MAT_RESET, '{MAX_Q, MAX_Q, MAX_Q}, 1, none});
      rows.push_back('{MAT_RESET, '{MIN_Q, MIN_Q, MIN_Q}, 1, none});
      rows.push_back('{MAT_RESET, '{MAX_Q, MIN_Q, 32'hFFFF_FFFF}, 1, none});
      // w = z: threshold edges, negative w, saturation
      rows.push_back('{MAT_W_IS_Z, '{ONE_Q, ONE_Q, 32'h0}, 1, none});
      rows.push_back('{MAT_W_IS_Z, '{ONE_Q, ONE_Q, 32'd654}, 1, none});
      rows.push_back('{MAT_W_IS_Z, '{ONE_Q, ONE_Q, 32'hFFFF_FFFF}, 1, none});
      rows.push_back('{MAT_W_IS_Z, '{MAX_Q, MAX_Q, MIN_Q}, 1, none});
      rows.push_back('{MAT_W_IS_Z, '{32'h0, 32'h0, 32'd655}, 1,
                       '{1'b1, 32'(HALF_X << 16), 32'(HALF_Y << 16)}});
      rows.push_back('{MAT_W_IS_Z, '{MAX_Q, 32'h0, 32'd655}, 1,
                       '{1'b1, MAX_Q, 32'(HALF_Y << 16)}});
      rows.push_back('{MAT_W_IS_Z, '{32'h0, MIN_Q, 32'd655}, 1,
                       '{1'b1, 32'(HALF_X << 16), MIN_Q}});
      rows.push_back('{MAT_W_IS_Z, '{ONE_Q, 32'hFFFF_0000, 32'd656}, 0, none});
      rows.push_back('{MAT_W_IS_Z, '{ONE_Q, 32'hFFFF_0000, ONE_Q}, 0, none});
      rows.push_back('{MAT_W_IS_Z, '{32'h0000_8000, 32'h0012_3456, MAX_Q}, 0, none});
      rows.push_back('{MAT_W_IS_Z, '{MIN_Q, MAX_Q, MAX_Q}, 0, none});
      rows.push_back('{MAT_ALL_ONES, '{32'h0, 32'h0, 32'h0}, 1, none});
      rows.push_back('{MAT_ALL_ONES, '{MIN_Q, MIN_Q, MIN_Q}, 0, none});
      rows.push_back('{MAT_ALL_ONES, '{32'hFFFF_0000, 32'h0, 32'h0}, 0, none});
      rows.push_back('{MAT_ALL_MIN, '{32'h0, 32'h0, 32'h0}, 1, none});
      rows.push_back('{MAT_ALL_MIN, '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000}, 0, none});
      rows.push_back('{MAT_ALL_MIN, '{MIN_Q, MIN_Q, MIN_Q}, 0, none});
      rows.push_back('{MAT_ALL_MAX, '{ONE_Q, 32'h0, 32'h0}, 0, none});
      rows.push_back('{MAT_ALL_MAX, '{MAX_Q, MAX_Q, MAX_Q}, 0, none});
      rows.push_back('{MAT_ALL_MAX, '{MIN_Q, 32'h0, 32'h0}, 1, none});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur = MAT_RESET;
      foreach (rows[i]) begin
         row = rows[i];
         if (row.kind != cur) begin
            req_valid <= 1'b0;
            drain();
            for (int k = 0; k < NUM_PAIRS; k++) csr_write(k, matrix_pair(row.kind, k));
            cur = row.kind;
         end
         send_point(row.pt, row.known, row.res);
      end

      per_phase = NUM_RANDOM / NUM_PHASES;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // sender pauses here until every result is back
         req_valid <= 1'b0;
         drain();
         sane = (ph % 4 != 1);
         for (int k = 0; k < NUM_PAIRS; k++) begin
            logic [31:0] lo, hi;
            lo = rand_coef(sane);
            hi = rand_coef(sane);
            // keep w mostly above the floor for well-formed matrices
            if (sane && k == 7) begin
               lo = 32'($urandom_range(0, 1 << 16));
               hi = 32'($urandom_range(1, 300)) << 16;
            end
            if (sane && k == 6) begin
               lo = 32'($urandom_range(0, 2048)) - 32'd1024;
               hi = 32'($urandom_range(0, 2048)) - 32'd1024;
            end
            csr_write(k, {hi, lo});
         end
         if (ph == 2) long_stall_req = 1;
         burst = 0;
         for (int n = 0; n < per_phase; n++) begin
            send_point(rand_point(), 1'b0, none);
            if (burst == 0) begin
               int gap;
               burst = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end else
               burst--;
         end
      end
      req_valid <= 1'b0;
      drain();

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
